>>> hdl/max_ratio_cycle_search_top_macros.svh
// Assertion macros shared by the checker of the max ratio cycle search block.
// Depends on nothing; include by bare file name.
`ifndef MAX_RATIO_CYCLE_SEARCH_TOP_MACROS_SVH
`define MAX_RATIO_CYCLE_SEARCH_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MRCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a plain expression on every rising clock edge outside reset.
`define MRCS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    `MRCS_ASSERT(lbl, clk, rst_n, 1'b1 |-> (expr), msg)

`endif

>>> hdl/mrcs_pkg.sv
// Package for the max ratio cycle search block: item types, codes, constants.
// Used by mrcs_ram users, the top level and the checker.
package mrcs_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 8192;
    localparam int DEF_FRAC_BITS = 20;

    localparam int MODE_W     = 2;
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 10;
    localparam int TIME_W     = 10;
    localparam int RATIO_W    = 31;
    localparam int CNT_W      = 11;
    localparam int DIST_W     = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_UPPER = 8'd1;

    localparam logic signed [DIST_W-1:0] DIST_FLOOR = 64'shC000_0000_0000_0000;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  node_index;
        logic [VAL_W-1:0]  node_value;
        logic [IDX_W-1:0]  edge_target;
        logic [TIME_W-1:0] edge_time;
    } t_in_item;

    typedef struct packed {
        logic [RATIO_W-1:0] best_ratio;
        logic               edges_dropped;
    } t_out_item;

endpackage

>>> hdl/mrcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module mrcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

>>> hdl/max_ratio_cycle_search_top.sv
// Max ratio cycle search: graph load, binary search over queue-based relaxation.
// Depends on mrcs_pkg and mrcs_ram.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Load and edge items are taken one per cycle while no search runs and stream
// back to back; the edge-store write lands in the cycle after its item.
// A run item holds the input for the whole search: about 31 probes, each of
// a check state, a scratch init over the nodes in use, S_POP, S_U, S_U2, S_E per
// queue pop and S_E to S_E5 per edge walked (S_E, S_E2 for an edge to a node
// outside use); every memory access goes through one registered-read port.
// After reset a clearing pass nulls each of the MAX_NODES adjacency heads;
// no item is taken meanwhile. Configuration writes are taken every cycle.
// A stalled result sits in the output register while loads keep flowing.
module max_ratio_cycle_search_top
    import mrcs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    // node address, node count, edge address, edge link widths
    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int LW  = $clog2(MAX_EDGES + 1);
    localparam int PW  = RATIO_W + TIME_W;
    localparam int EDW = LW + IDX_W + TIME_W;
    localparam int QW  = 1 + CW;

    // upper bound after reset: 2000 in fixed point, capped to the ratio range
    localparam logic [63:0] UP_FULL = 64'(2000) << FRAC_BITS;
    localparam logic [RATIO_W-1:0] UP_RST =
        (UP_FULL > 64'(RATIO_MAX)) ? RATIO_MAX : UP_FULL[RATIO_W-1:0];

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_INIT = 4'd3;
    localparam logic [3:0] S_POP  = 4'd4;
    localparam logic [3:0] S_U    = 4'd5;
    localparam logic [3:0] S_U2   = 4'd6;
    localparam logic [3:0] S_E    = 4'd7;
    localparam logic [3:0] S_E2   = 4'd8;
    localparam logic [3:0] S_E3   = 4'd9;
    localparam logic [3:0] S_E4   = 4'd10;
    localparam logic [3:0] S_E5   = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    // control registers
    logic [3:0]         r_state, n_state;
    logic [NW-1:0]      r_clr, n_clr;
    logic [CNT_W-1:0]   r_node_count, n_node_count;
    logic [RATIO_W-1:0] r_upper, n_upper;
    logic [LW-1:0]      r_edges, n_edges;
    logic               r_ovf, n_ovf;
    logic               r_pend, n_pend;
    logic               r_ovalid, n_ovalid;

    // datapath registers
    logic [EAW-1:0]           r_pend_addr, n_pend_addr;
    logic [IDX_W-1:0]         r_pend_dest, n_pend_dest;
    logic [TIME_W-1:0]        r_pend_time, n_pend_time;
    logic [CW-1:0]            r_n, n_n;
    logic signed [32:0]       r_lo, n_lo, r_hi, n_hi;
    logic [RATIO_W-1:0]       r_x, n_x, r_best, n_best;
    logic [CW-1:0]            r_i, n_i, r_fill, n_fill;
    logic [NW-1:0]            r_rd, n_rd, r_wr, n_wr, r_u, n_u, r_v, n_v;
    logic signed [DIST_W-1:0] r_gain, n_gain, r_du, n_du;
    logic signed [DIST_W-1:0] r_cost, n_cost, r_cand, n_cand;
    logic [LW-1:0]            r_link, n_link;
    logic [PW-1:0]            r_prod, n_prod;
    t_out_item                r_oitem, n_oitem;

    // memory ports
    logic             val_we, val_re;
    logic [NW-1:0]    val_waddr, val_raddr;
    logic [VAL_W-1:0] val_wdata, val_rdata;
    logic             head_we, head_re;
    logic [NW-1:0]    head_waddr, head_raddr;
    logic [LW-1:0]    head_wdata, head_rdata;
    logic             edge_we, edge_re;
    logic [EAW-1:0]   edge_waddr, edge_raddr;
    logic [EDW-1:0]   edge_wdata, edge_rdata;
    logic             dist_we, dist_re;
    logic [NW-1:0]    dist_waddr, dist_raddr;
    logic [DIST_W-1:0] dist_wdata, dist_rdata;
    logic             qt_we, qt_re;
    logic [NW-1:0]    qt_waddr, qt_raddr;
    logic [QW-1:0]    qt_wdata, qt_rdata;
    logic             fifo_we, fifo_re;
    logic [NW-1:0]    fifo_waddr, fifo_raddr;
    logic [NW-1:0]    fifo_wdata, fifo_rdata;

    logic                     in_acc;
    logic [32:0]              mid_sum;
    logic signed [DIST_W-1:0] sum_d;
    logic [LW-1:0]            e_link;
    logic [IDX_W-1:0]         e_dest;
    logic [TIME_W-1:0]        e_time;
    logic [CW-1:0]            tally_inc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;
    assign in_acc      = i_in_valid && o_in_ready;

    assign mid_sum   = r_lo + r_hi;
    assign sum_d     = r_du + r_cost;
    assign e_link    = edge_rdata[EDW-1 -: LW];
    assign e_dest    = edge_rdata[IDX_W+TIME_W-1 -: IDX_W];
    assign e_time    = edge_rdata[TIME_W-1:0];
    assign tally_inc = qt_rdata[CW-1:0] + CW'(1);

    always_comb begin
        n_state = r_state;      n_clr = r_clr;
        n_node_count = r_node_count; n_upper = r_upper;
        n_edges = r_edges;      n_ovf = r_ovf;
        n_pend = 1'b0;          n_ovalid = r_ovalid;
        n_pend_addr = r_pend_addr; n_pend_dest = r_pend_dest;
        n_pend_time = r_pend_time;
        n_n = r_n;   n_lo = r_lo;   n_hi = r_hi;   n_x = r_x;   n_best = r_best;
        n_i = r_i;   n_fill = r_fill; n_rd = r_rd; n_wr = r_wr;
        n_u = r_u;   n_v = r_v;     n_gain = r_gain; n_du = r_du;
        n_cost = r_cost; n_cand = r_cand; n_link = r_link; n_prod = r_prod;
        n_oitem = r_oitem;

        val_we = 1'b0;  val_waddr = NW'(i_in_item.node_index);
        val_wdata = i_in_item.node_value;
        val_re = 1'b0;  val_raddr = fifo_rdata;
        head_we = 1'b0; head_waddr = NW'(i_in_item.node_index);
        head_wdata = r_edges + LW'(1);
        head_re = 1'b0; head_raddr = NW'(i_in_item.node_index);
        edge_we = r_pend; edge_waddr = r_pend_addr;
        edge_wdata = {head_rdata, r_pend_dest, r_pend_time};
        edge_re = 1'b0; edge_raddr = EAW'(r_link - LW'(1));
        dist_we = 1'b0; dist_waddr = NW'(r_i); dist_wdata = '0;
        dist_re = 1'b0; dist_raddr = fifo_rdata;
        qt_we = 1'b0;   qt_waddr = NW'(r_i); qt_wdata = {1'b1, CW'(1)};
        qt_re = 1'b0;   qt_raddr = fifo_rdata;
        fifo_we = 1'b0; fifo_waddr = NW'(r_i); fifo_wdata = NW'(r_i);
        fifo_re = 1'b0; fifo_raddr = r_rd;

        // configuration
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT:   n_node_count = i_cfg_data[CNT_W-1:0];
                CFG_SEARCH_UPPER: n_upper = i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end

        // drop the result once taken
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = '0;
                n_clr      = r_clr + NW'(1);
                if (32'(r_clr) == MAX_NODES - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_item.mode)
                        MODE_LOAD: begin
                            val_we = (32'(i_in_item.node_index) < MAX_NODES);
                        end
                        MODE_EDGE: begin
                            if (32'(i_in_item.node_index) < MAX_NODES) begin
                                if (32'(r_edges) >= MAX_EDGES) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    // new head now, old head links in next cycle
                                    head_we     = 1'b1;
                                    head_re     = 1'b1;
                                    n_pend      = 1'b1;
                                    n_pend_addr = EAW'(r_edges);
                                    n_pend_dest = i_in_item.edge_target;
                                    n_pend_time = i_in_item.edge_time;
                                    n_edges     = r_edges + LW'(1);
                                end
                            end
                        end
                        MODE_RUN: begin
                            n_n = (32'(r_node_count) > MAX_NODES) ? CW'(MAX_NODES)
                                                                  : CW'(r_node_count);
                            n_lo    = '0;
                            n_hi    = $signed({2'b00, r_upper});
                            n_best  = '0;
                            n_state = S_CHK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHK: begin
                if (r_lo < r_hi) begin
                    n_x     = mid_sum[31:1];
                    n_i     = '0;
                    n_state = S_INIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INIT: begin
                if (r_i < r_n) begin
                    dist_we = 1'b1;
                    qt_we   = 1'b1;
                    fifo_we = 1'b1;
                    n_i     = r_i + CW'(1);
                end else begin
                    n_rd    = '0;
                    n_wr    = (32'(r_n) == MAX_NODES) ? '0 : NW'(r_n);
                    n_fill  = r_n;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_fill == '0) begin
                    // queue drained: no negative cycle at this ratio
                    n_hi    = $signed({2'b00, r_x}) - 33'sd1;
                    n_state = S_CHK;
                end else begin
                    fifo_re = 1'b1;
                    n_rd    = (32'(r_rd) == MAX_NODES - 1) ? '0 : r_rd + NW'(1);
                    n_fill  = r_fill - CW'(1);
                    n_state = S_U;
                end
            end
            S_U: begin
                n_u     = fifo_rdata;
                val_re  = 1'b1;
                head_re = 1'b1;
                head_raddr = fifo_rdata;
                dist_re = 1'b1;
                qt_re   = 1'b1;
                n_state = S_U2;
            end
            S_U2: begin
                n_gain   = $signed(DIST_W'(val_rdata) << FRAC_BITS);
                n_link   = head_rdata;
                n_du     = $signed(dist_rdata);
                qt_we    = 1'b1;
                qt_waddr = r_u;
                qt_wdata = {1'b0, qt_rdata[CW-1:0]};
                n_state  = S_E;
            end
            S_E: begin
                if (r_link == '0) begin
                    n_state = S_POP;
                end else begin
                    edge_re = 1'b1;
                    n_state = S_E2;
                end
            end
            S_E2: begin
                n_link = e_link;
                if (32'(e_dest) < 32'(r_n)) begin
                    n_prod     = PW'(r_x) * PW'(e_time);
                    n_v        = NW'(e_dest);
                    dist_re    = 1'b1;
                    dist_raddr = NW'(e_dest);
                    qt_re      = 1'b1;
                    qt_raddr   = NW'(e_dest);
                    n_state    = S_E3;
                end else begin
                    n_state = S_E;
                end
            end
            S_E3: begin
                n_cost  = $signed({{(DIST_W-PW){1'b0}}, r_prod}) - r_gain;
                n_state = S_E4;
            end
            S_E4: begin
                n_cand  = (sum_d < DIST_FLOOR) ? DIST_FLOOR : sum_d;
                n_state = S_E5;
            end
            S_E5: begin
                n_state = S_E;
                if ($signed(dist_rdata) > r_cand) begin
                    dist_we    = 1'b1;
                    dist_waddr = r_v;
                    dist_wdata = r_cand;
                    if (r_v == r_u) begin
                        n_du = r_cand;
                    end
                    if (!qt_rdata[CW]) begin
                        fifo_we    = 1'b1;
                        fifo_waddr = r_wr;
                        fifo_wdata = r_v;
                        n_wr   = (32'(r_wr) == MAX_NODES - 1) ? '0 : r_wr + NW'(1);
                        n_fill = r_fill + CW'(1);
                        qt_we    = 1'b1;
                        qt_waddr = r_v;
                        qt_wdata = {1'b1, tally_inc};
                        if (tally_inc >= r_n) begin
                            // negative cycle: ratio is feasible
                            n_best  = r_x;
                            n_lo    = $signed({2'b00, r_x}) + 33'sd1;
                            n_state = S_CHK;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oitem  = '{best_ratio: r_best, edges_dropped: r_ovf};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_node_count <= CNT_W'(1);
            r_upper      <= UP_RST;
            r_edges      <= '0;
            r_ovf        <= 1'b0;
            r_pend       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_node_count <= n_node_count;
            r_upper      <= n_upper;
            r_edges      <= n_edges;
            r_ovf        <= n_ovf;
            r_pend       <= n_pend;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_pend_dest <= n_pend_dest;
        r_pend_time <= n_pend_time;
        r_n    <= n_n;    r_lo   <= n_lo;   r_hi   <= n_hi;
        r_x    <= n_x;    r_best <= n_best; r_i    <= n_i;
        r_fill <= n_fill; r_rd   <= n_rd;   r_wr   <= n_wr;
        r_u    <= n_u;    r_v    <= n_v;    r_gain <= n_gain;
        r_du   <= n_du;   r_cost <= n_cost; r_cand <= n_cand;
        r_link <= n_link; r_prod <= n_prod; r_oitem <= n_oitem;
    end

    mrcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_val_ram (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(val_wdata),
        .i_re(val_re), .i_raddr(val_raddr), .o_rdata(val_rdata)
    );
    mrcs_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_head_ram (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_re(head_re), .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    mrcs_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_re(edge_re), .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );
    mrcs_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_waddr), .i_wdata(dist_wdata),
        .i_re(dist_re), .i_raddr(dist_raddr), .o_rdata(dist_rdata)
    );
    mrcs_ram #(.WIDTH(QW), .DEPTH(MAX_NODES)) u_qt_ram (
        .i_clk(i_clk), .i_we(qt_we), .i_waddr(qt_waddr), .i_wdata(qt_wdata),
        .i_re(qt_re), .i_raddr(qt_raddr), .o_rdata(qt_rdata)
    );
    mrcs_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fifo_ram (
        .i_clk(i_clk), .i_we(fifo_we), .i_waddr(fifo_waddr), .i_wdata(fifo_wdata),
        .i_re(fifo_re), .i_raddr(fifo_raddr), .o_rdata(fifo_rdata)
    );
endmodule

>>> hdl/mrcs_checker.sv
// Port checker for the max ratio cycle search top level, bound to it below.
// Depends on mrcs_pkg and max_ratio_cycle_search_top_macros.svh.
`include "max_ratio_cycle_search_top_macros.svh"
module mrcs_checker
    import mrcs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_item              i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_item,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);
    `MRCS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")
    `MRCS_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_item), "stalled result changed")
    `MRCS_ASSERT(a_run_blocks, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_item.mode == MODE_RUN |=> !o_in_ready, "input open right after a run item")
    `MRCS_ASSERT_ALWAYS(a_cfg_open, i_clk, i_rst_n, o_cfg_ready, "configuration port not ready")
    `MRCS_ASSERT(a_cfg_idle, i_clk, i_rst_n, i_cfg_valid |-> o_in_ready && !$isunknown({i_cfg_index, i_cfg_data}), "configuration write while busy")
endmodule

bind max_ratio_cycle_search_top mrcs_checker u_mrcs_checker (.*);

>>> dv/tb_max_ratio_cycle_search_top.sv
// Testbench for max_ratio_cycle_search_top: streams node loads, edges and search runs.
// Checks every search result against a scoreboard class holding its own graph model.
// Depends on mrcs_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_max_ratio_cycle_search_top;
    import mrcs_pkg::*;

    localparam int NODES      = DEF_MAX_NODES;
    localparam int EDGES      = DEF_MAX_EDGES;
    localparam int FRAC       = DEF_FRAC_BITS;
    localparam int CYCLE_CAP  = 30_000_000;
    localparam int DRAIN_WAIT = 16;

    // Idling schemes, cycled through the random phases.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    // Scoreboard: mirrors the graph store and computes each search result.
    class ratio_scoreboard;
        bit [VAL_W-1:0]  node_val [NODES];
        int unsigned     head_link [NODES];
        int unsigned     next_link [EDGES];
        bit [IDX_W-1:0]  edge_to [EDGES];
        bit [TIME_W-1:0] edge_wt [EDGES];
        int unsigned     edge_cnt;
        bit              dropped;
        int unsigned     node_cnt;
        longint          upper;
        longint          node_dist [NODES];
        bit              in_ring [NODES];
        int unsigned     tally [NODES];
        int unsigned     ring [NODES];
        t_out_item       ratio_q [$];
        int              errors;
        int              searches;
        int              checked;

        function new();
            node_cnt = 1;
            upper    = 2000 << FRAC;
            edge_cnt = 0;
            dropped  = 0;
            errors   = 0;
            searches = 0;
            checked  = 0;
            foreach (head_link[i]) head_link[i] = 0;
            foreach (node_val[i]) node_val[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_NODE_COUNT) node_cnt = d[CNT_W-1:0];
            else if (idx == CFG_SEARCH_UPPER) upper = longint'(d[RATIO_W-1:0]);
        endfunction

        // Relax from all nodes at once; report a node queued n times.
        function bit has_neg_cycle(longint unsigned x, int unsigned n);
            int unsigned rd, wr, fill, u, lnk, e, v;
            longint gain, cost, cand;
            rd = 0;
            wr = 0;
            fill = 0;
            for (int i = 0; i < n; i++) begin
                ring[wr] = i;
                wr = (wr + 1) % NODES;
                fill++;
                node_dist[i] = 0;
                in_ring[i] = 1;
                tally[i] = 1;
            end
            while (fill > 0) begin
                u = ring[rd];
                rd = (rd + 1) % NODES;
                fill--;
                in_ring[u] = 0;
                gain = longint'(node_val[u]) << FRAC;
                lnk = head_link[u];
                while (lnk != 0) begin
                    e = lnk - 1;
                    v = edge_to[e];
                    cost = longint'(x * longint'(edge_wt[e])) - gain;
                    lnk = next_link[e];
                    if (v >= n) continue;
                    cand = node_dist[u];
                    // saturate deep distances at the floor
                    if (cost < 0 && cand < DIST_FLOOR - cost) cand = DIST_FLOOR;
                    else cand += cost;
                    if (node_dist[v] > cand) begin
                        node_dist[v] = cand;
                        if (!in_ring[v]) begin
                            ring[wr] = v;
                            wr = (wr + 1) % NODES;
                            fill++;
                            in_ring[v] = 1;
                            tally[v]++;
                            if (tally[v] >= n) return 1;
                        end
                    end
                end
            end
            return 0;
        endfunction

        function void note_item(t_in_item it);
            int unsigned n;
            longint lo, hi;
            longint unsigned mid, best;
            t_out_item r;
            case (it.mode)
                MODE_LOAD: node_val[it.node_index] = it.node_value;
                MODE_EDGE: begin
                    if (edge_cnt >= EDGES) begin
                        dropped = 1;
                    end else begin
                        edge_to[edge_cnt] = it.edge_target;
                        edge_wt[edge_cnt] = it.edge_time;
                        next_link[edge_cnt] = head_link[it.node_index];
                        head_link[it.node_index] = edge_cnt + 1;
                        edge_cnt++;
                    end
                end
                MODE_RUN: begin
                    n = node_cnt > NODES ? NODES : node_cnt;
                    lo = 0;
                    hi = upper;
                    best = 0;
                    while (lo < hi) begin
                        mid = longint'(lo + hi) >> 1;
                        if (has_neg_cycle(mid, n)) begin
                            best = mid;
                            lo = longint'(mid) + 1;
                        end else begin
                            hi = longint'(mid) - 1;
                        end
                    end
                    r.best_ratio = best[RATIO_W-1:0];
                    r.edges_dropped = dropped;
                    ratio_q.push_back(r);
                    searches++;
                end
                default: ; // mode 3: ignored
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (ratio_q.size() == 0) begin
                $error("unexpected result: best_ratio %0d edges_dropped %0d",
                       got.best_ratio, got.edges_dropped);
                errors++;
                return;
            end
            want = ratio_q.pop_front();
            checked++;
            if (got.best_ratio !== want.best_ratio) begin
                $error("best_ratio: expected %0d, actual %0d", want.best_ratio, got.best_ratio);
                errors++;
            end
            if (got.edges_dropped !== want.edges_dropped) begin
                $error("edges_dropped: expected %0d, actual %0d",
                       want.edges_dropped, got.edges_dropped);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ratio_scoreboard sb;
    t_idle           idle_mode;
    int              hold_off;
    int              items_sent;
    longint          cycle_cnt;

    max_ratio_cycle_search_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_CAP) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: check accepted results, then pick next ready.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
            if (hold_off > 0) begin
                // long hold-off so the block backs up and stalls its input
                hold_off--;
                i_out_ready <= 1'b0;
            end else if (idle_mode == IDLE_RECEIVER) begin
                i_out_ready <= ($urandom_range(0, 99) >= 81);
            end else if (idle_mode == IDLE_BOTH) begin
                i_out_ready <= ($urandom_range(0, 99) >= 20);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic int sender_idle_pct();
        if (idle_mode == IDLE_SENDER) return 81;
        if (idle_mode == IDLE_BOTH) return 20;
        return 0;
    endfunction

    // Offer one item, with random idle cycles ahead of it; leave valid high afterward.
    task automatic send_item(t_in_item it);
        int pct;
        pct = sender_idle_pct();
        while ($urandom_range(0, 99) < pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    // Drop valid and wait for all pending searches plus trailing writes.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.ratio_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    // Random filler in every field; callers override the ones that matter.
    function automatic t_in_item build(logic [MODE_W-1:0] m);
        logic [63:0] raw;
        t_in_item    it;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.mode = m;
        return it;
    endfunction

    function automatic t_in_item edge_item(int src, int dst, int tm);
        t_in_item it;
        it = build(MODE_EDGE);
        it.node_index  = IDX_W'(src);
        it.edge_target = IDX_W'(dst);
        it.edge_time   = TIME_W'(tm);
        return it;
    endfunction

    function automatic t_in_item load_item(int idx, int val);
        t_in_item it;
        it = build(MODE_LOAD);
        it.node_index = IDX_W'(idx);
        it.node_value = VAL_W'(val);
        return it;
    endfunction

    task automatic random_phase(int phase);
        int n, cnt, pick;
        t_in_item it;
        n = $urandom_range(1, 6);
        write_reg(CFG_NODE_COUNT, n);
        if ($urandom_range(0, 1)) write_reg(CFG_SEARCH_UPPER, $urandom_range(0, 1 << 14));
        else write_reg(CFG_SEARCH_UPPER, $urandom & RATIO_MAX);
        idle_mode = t_idle'(phase % 4);
        cnt = $urandom_range(8, 14);
        for (int k = 0; k < cnt; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                it = load_item($urandom_range(0, 7), $urandom_range(0, 1023));
            end else if (pick < 45) begin
                // edge from a node in use to a node in use or just past them: builds cycles
                it = edge_item($urandom_range(0, n - 1), $urandom_range(0, n), $urandom_range(0, 1023));
            end else if (pick < 88) begin
                it = build(pick < 70 ? MODE_EDGE : MODE_LOAD);
                if (it.mode == MODE_EDGE && it.node_index < 8) it.node_index += 8;
            end else if (pick < 94) begin
                it = build(MODE_IGNORE);
            end else begin
                it = build(MODE_RUN);
            end
            send_item(it);
        end
        send_item(build(MODE_RUN));
    endtask

    initial begin
        sb = new();
        idle_mode   = IDLE_NONE;
        hold_off    = 0;
        items_sent  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Write every node value first so no search ever reads an unwritten one.
        for (int i = 0; i < NODES; i++) begin
            send_item(load_item(i, (i == 0) ? 1023 : (i == NODES - 1) ? 0 : $urandom_range(0, 1023)));
        end

        // Directed: defaults, self loops, extremes, ignored mode, out-of-use target.
        send_item(build(MODE_RUN));
        send_item(edge_item(0, 0, 1023));
        send_item(build(MODE_RUN));
        send_item(edge_item(0, 1, 0));
        send_item(edge_item(1, 0, 0));
        send_item(edge_item(1023, 1023, 1023));
        send_item(build(MODE_IGNORE));
        send_item(load_item(1, 1023));
        send_item(build(MODE_RUN));
        write_reg(CFG_NODE_COUNT, 2);
        write_reg(CFG_SEARCH_UPPER, RATIO_MAX);
        send_item(build(MODE_RUN));
        send_item(load_item(0, 0));
        send_item(edge_item(1, 1, 1));
        send_item(build(MODE_RUN));
        write_reg(CFG_SEARCH_UPPER, 0);
        send_item(build(MODE_RUN));
        write_reg(CFG_NODE_COUNT, NODES);
        send_item(build(MODE_RUN));
        // upper bits beyond the register width are masked off
        write_reg(CFG_NODE_COUNT, 32'hFFFF_F802);
        write_reg(CFG_SEARCH_UPPER, 32'hFFFF_F000);
        send_item(build(MODE_RUN));
        write_reg(CFG_SEARCH_UPPER, 4096);
        send_item(build(MODE_RUN));

        for (int p = 0; p < 6; p++) random_phase(p);

        // Pressure: hold results off while runs and loads keep arriving.
        write_reg(CFG_NODE_COUNT, 2);
        write_reg(CFG_SEARCH_UPPER, 1 << 12);
        idle_mode = IDLE_NONE;
        hold_off = 4000;
        send_item(build(MODE_RUN));
        send_item(load_item(5, 17));
        send_item(build(MODE_RUN));
        send_item(build(MODE_RUN));
        send_item(load_item(6, 900));
        wait_drained();
        repeat (100) @(posedge i_clk);

        if (sb.ratio_q.size() != 0) begin
            $error("%0d results never arrived", sb.ratio_q.size());
            sb.errors++;
        end
        $display("tb: %0d items sent, %0d searches predicted, %0d results checked",
                 items_sent, sb.searches, sb.checked);
        $display("tb: covered defaults, extremes, masked writes, idle mixes and backpressure");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
